>>> rtl/rgbfb_pkg.sv
// Shared types, codes and helpers for the RGB565 framebuffer blend store.
// No dependencies; rgbfb_ctrl, rgbfb_dp and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package rgbfb_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 160;
   localparam int SCREEN_HEIGHT_DEFAULT = 128;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   // Request codes; code 3 is unused and answered as a no-op
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   // Source of the result word
   typedef enum logic [1:0] {
      RSP_ZERO  = 2'd0,
      RSP_OFF   = 2'd1,
      RSP_READ  = 2'd2,
      RSP_COLOR = 2'd3
   } rsp_sel_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pixel_value;
      logic        off_screen;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic        req_load;
      logic        addr_load;
      logic        ram_re;
      logic        mix_load;
      logic        ram_we_pixel;
      logic        clear_step;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] req_kind;
      logic       on_screen;
      logic       opaque;
      logic       clear_last;
   } dp_stat_type;

   // floor(v / 255) for v below 64 * 255, used on blend sums up to 63 * 255
   function automatic logic [5:0] div255(input logic [13:0] v);
      logic [14:0] t;
      logic [14:0] s;
      t = 15'(v) + 15'd1;
      s = t + (t >> 8);
      return s[13:8];
   endfunction

endpackage

`default_nettype wire

>>> rtl/rgb565_framebuffer_blend_store.sv
// RGB565 framebuffer with alpha-blended pixel writes: top level.
// Depends on rgbfb_pkg, rgbfb_ctrl, rgbfb_dp (and rgbfb_ram below it).
//
//   port group   dir  handshake             payload
//   req_*        in   req_valid/req_ready   req_payload_type
//   rsp_*        out  rsp_valid/rsp_ready   rsp_payload_type
//   csr_*        in   csr_wr_en             address_mode (1 bit)
//
// One transaction at a time through a multi-cycle controller. After
// ST_ADDR, an opaque write goes to ST_WRITE, an off-screen request to
// ST_DONE, a read to ST_FETCH and ST_RDONE, a blended write to ST_FETCH,
// ST_MIX and ST_WRITE (one RAM read, one multiply stage, one write), and
// a clear to ST_CLEAR and ST_DONE; ST_CLEAR sweeps DEPTH = SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT/8) * 8 entries (20480 at the defaults), writing one
// RAM entry a cycle. After reset the same sweep runs with req_ready low.
// A result waits in the output register; a stalled rsp_ready holds the
// controller only at the point where it must publish the next result.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_framebuffer_blend_store_core #(
   parameter int SCREEN_WIDTH  = rgbfb_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = rgbfb_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire rgbfb_pkg::req_payload_type  req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output rgbfb_pkg::rsp_payload_type       rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data
);
   import rgbfb_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rgbfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rgbfb_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

   // a pixel write goes only to an on-screen address of a write transaction
   assert property (@(posedge clock) disable iff (reset)
      cmd.ram_we_pixel |-> (stat.on_screen && stat.req_kind == REQ_WRITE))
      else $error("pixel write for a clipped or non-write transaction");

   // never overwrite a result that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before acceptance");

   // no new transaction while the store is being swept
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req_ready)
      else $error("request accepted during clear sweep");

   // one transaction in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted back to back");

endmodule

`default_nettype wire

>>> rtl/rgbfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rgbfb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      // hold read data between reads
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/rgbfb_ctrl.sv
// Controller state machine: sequences one transaction at a time, the clear
// sweep after reset and on request, and the result register handshake.
// Depends on rgbfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbfb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rgbfb_pkg::dp_cmd_type  cmd,
   input  wire rgbfb_pkg::dp_stat_type stat
);
   import rgbfb_pkg::*;

   typedef enum logic [8:0] {
      ST_INIT  = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_ADDR  = 9'b000000100,
      ST_FETCH = 9'b000001000,
      ST_MIX   = 9'b000010000,
      ST_WRITE = 9'b000100000,
      ST_RDONE = 9'b001000000,
      ST_CLEAR = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rsp_sel = RSP_ZERO;
      case (state_ff)
         ST_INIT: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.addr_load = 1'b1;
            case (stat.req_kind)
               REQ_WRITE: begin
                  if (!stat.on_screen) begin
                     state_in = ST_DONE;
                  end else if (stat.opaque) begin
                     state_in = ST_WRITE;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
               REQ_READ: begin
                  state_in = stat.on_screen ? ST_FETCH : ST_DONE;
               end
               REQ_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_FETCH: begin
            cmd.ram_re = 1'b1;
            state_in   = (stat.req_kind == REQ_READ) ? ST_RDONE : ST_MIX;
         end
         ST_MIX: begin
            cmd.mix_load = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.rsp_sel = RSP_COLOR;
            // write and publish together once the result slot is free
            if (slot_free) begin
               cmd.ram_we_pixel = 1'b1;
               cmd.rsp_load     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_RDONE: begin
            cmd.rsp_sel = RSP_READ;
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // reads and writes land here only when off screen
            if (stat.req_kind == REQ_WRITE || stat.req_kind == REQ_READ) begin
               cmd.rsp_sel = RSP_OFF;
            end
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/rgbfb_dp.sv
// Datapath: request register, clipping and address mapping, alpha blend,
// clear counter, pixel RAM and result register.
// Depends on rgbfb_pkg and rgbfb_ram.
`timescale 1ns / 1ps
`default_nettype none

module rgbfb_dp #(
   parameter int SCREEN_WIDTH  = rgbfb_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = rgbfb_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic                       csr_wr_data,
   input  wire rgbfb_pkg::req_payload_type req_data,
   input  wire rgbfb_pkg::dp_cmd_type      cmd,
   output rgbfb_pkg::dp_stat_type          stat,
   output rgbfb_pkg::rsp_payload_type      rsp_data
);
   import rgbfb_pkg::*;

   localparam int DEPTH = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8) * 8;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(SCREEN_WIDTH);
   localparam int YW    = $clog2(SCREEN_HEIGHT);
   localparam logic [AW-1:0] ROW_STRIDE  = AW'(SCREEN_WIDTH);
   localparam logic [AW-1:0] PAGE_STRIDE = AW'(SCREEN_WIDTH * 8);
   localparam logic [AW-1:0] LAST_ADDR   = AW'(DEPTH - 1);

   req_payload_type req_ff;
   logic            address_mode_ff;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [13:0]     sum_r_ff, sum_g_ff, sum_b_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic            x_ok, y_ok;
   logic [XW-1:0]   x_idx;
   logic [YW-1:0]   y_idx;
   logic [AW-1:0]   addr_linear, addr_page;
   logic [4:0]      new_r, new_b;
   logic [5:0]      new_g;
   logic [7:0]      alpha_inv;
   logic [15:0]     ram_rdata;
   logic [4:0]      q_r, q_b;
   logic [5:0]      q_g;
   logic [15:0]     color;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [15:0]     ram_wdata;

   // clipping and address mapping
   assign x_ok  = !req_ff.x_coord[15] && (req_ff.x_coord[14:0] < 15'(SCREEN_WIDTH));
   assign y_ok  = !req_ff.y_coord[15] && (req_ff.y_coord[14:0] < 15'(SCREEN_HEIGHT));
   assign x_idx = req_ff.x_coord[XW-1:0];
   assign y_idx = req_ff.y_coord[YW-1:0];

   assign addr_linear = AW'(x_idx) + AW'(y_idx) * ROW_STRIDE;
   assign addr_page   = (AW'(x_idx) << 3) + AW'(y_idx[2:0])
                      + AW'(y_idx >> 3) * PAGE_STRIDE;
   assign addr_in     = address_mode_ff ? addr_page : addr_linear;

   // color truncation and blend
   assign new_r     = req_ff.red[7:3];
   assign new_g     = req_ff.green[7:2];
   assign new_b     = req_ff.blue[7:3];
   assign alpha_inv = ALPHA_OPAQUE - req_ff.alpha;

   // red and blue sums stay below 32 * 255, so their quotients fit in 5 bits
   assign q_r = 5'(div255(sum_r_ff));
   assign q_g = div255(sum_g_ff);
   assign q_b = 5'(div255(sum_b_ff));

   assign color = stat.opaque ? {new_r, new_g, new_b} : {q_r, q_g, q_b};

   // clear sweep counter wraps to zero after the last entry
   assign clr_cnt_in = !cmd.clear_step ? clr_cnt_ff :
                       (clr_cnt_ff == LAST_ADDR) ? '0 : clr_cnt_ff + 1'b1;

   assign stat.req_kind   = req_ff.req_type;
   assign stat.on_screen  = x_ok && y_ok;
   assign stat.opaque     = (req_ff.alpha == ALPHA_OPAQUE);
   assign stat.clear_last = (clr_cnt_ff == LAST_ADDR);

   assign ram_we    = cmd.ram_we_pixel || cmd.clear_step;
   assign ram_waddr = cmd.clear_step ? clr_cnt_ff : addr_ff;
   assign ram_wdata = cmd.clear_step ? 16'd0 : color;

   rgbfb_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.ram_re),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_in = '0;
      case (cmd.rsp_sel)
         RSP_ZERO: begin
            rsp_in = '0;
         end
         RSP_OFF: begin
            rsp_in.off_screen = 1'b1;
         end
         RSP_READ: begin
            rsp_in.pixel_value = ram_rdata;
         end
         RSP_COLOR: begin
            rsp_in.pixel_value = color;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_mode_ff <= 1'b0;
         clr_cnt_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            address_mode_ff <= csr_wr_data;
         end
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      if (cmd.addr_load) begin
         addr_ff <= addr_in;
      end
      if (cmd.mix_load) begin
         sum_r_ff <= 14'(ram_rdata[15:11]) * 14'(alpha_inv) + 14'(new_r) * 14'(req_ff.alpha);
         sum_g_ff <= 14'(ram_rdata[10:5])  * 14'(alpha_inv) + 14'(new_g) * 14'(req_ff.alpha);
         sum_b_ff <= 14'(ram_rdata[4:0])   * 14'(alpha_inv) + 14'(new_b) * 14'(req_ff.alpha);
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> tb/sv/rgb565_framebuffer_blend_store_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rgb565_framebuffer_blend_store_core: directed rows, then random
// drawing traffic in both address modes, scored against an in-bench pixel store predictor.
// Depends on rgbfb_pkg and the core RTL only.

module rgb565_framebuffer_blend_store_core_tb;
   import rgbfb_pkg::*;

   localparam int SCREEN_W    = SCREEN_WIDTH_DEFAULT;
   localparam int SCREEN_H    = SCREEN_HEIGHT_DEFAULT;
   localparam int STORE_WORDS = SCREEN_W * ((SCREEN_H + 7) / 8) * 8;
   localparam int ROW_GROUP   = 8;
   localparam int STALL_LIMIT = 120000;
   localparam int LONG_HOLD   = 500;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 305;
   localparam logic [1:0] REQ_SPARE = 2'd3;
   localparam bit MODE_LINEAR = 1'b0;
   localparam bit MODE_PAGED  = 1'b1;

   typedef struct {
      req_payload_type rq;
      bit              fixed;
      rsp_payload_type want;
   } stim_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_wr_en;
   logic            csr_wr_data;

   logic [15:0]     pixel_mem [STORE_WORDS];
   bit              page_mode;
   rsp_payload_type pixel_expect_q [$];
   int              error_count;
   int              results_seen;
   bit              quiet_tail;

   rgb565_framebuffer_blend_store_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned blend_channel(int unsigned oldc, int unsigned newc,
                                                 int unsigned a);
      int unsigned full;
      full = ALPHA_OPAQUE;
      return ((full - a) * oldc + a * newc) / full;
   endfunction

   // Compute the response for one request and update the shadow store.
   function automatic rsp_payload_type predict_pixel(req_payload_type rq);
      rsp_payload_type res;
      int              x;
      int              y;
      int unsigned     addr;
      logic [15:0]     old;
      logic [4:0]      r;
      logic [5:0]      g;
      logic [4:0]      b;
      res = '0;
      x = $signed(rq.x_coord);
      y = $signed(rq.y_coord);
      if (rq.req_type == REQ_WRITE || rq.req_type == REQ_READ) begin
         if (x < 0 || y < 0 || x >= SCREEN_W || y >= SCREEN_H) begin
            res.off_screen = 1'b1;
         end else begin
            if (page_mode)
               addr = x * ROW_GROUP + y % ROW_GROUP + (y / ROW_GROUP) * SCREEN_W * ROW_GROUP;
            else
               addr = x + y * SCREEN_W;
            if (rq.req_type == REQ_READ) begin
               res.pixel_value = pixel_mem[addr];
            end else begin
               r = rq.red[7:3];
               g = rq.green[7:2];
               b = rq.blue[7:3];
               if (rq.alpha != ALPHA_OPAQUE) begin
                  old = pixel_mem[addr];
                  r = 5'(blend_channel(old[15:11], r, rq.alpha));
                  g = 6'(blend_channel(old[10:5], g, rq.alpha));
                  b = 5'(blend_channel(old[4:0], b, rq.alpha));
               end
               res.pixel_value = {r, g, b};
               pixel_mem[addr] = res.pixel_value;
            end
         end
      end else if (rq.req_type == REQ_CLEAR) begin
         foreach (pixel_mem[i]) pixel_mem[i] = '0;
      end
      return res;
   endfunction

   function automatic stim_row_type mk_row(logic [1:0] kind, int x, int y, int r, int g,
                                           int b, int a, bit fixed, int pv, bit off);
      stim_row_type row;
      row.rq.req_type     = kind;
      row.rq.x_coord      = 16'(x);
      row.rq.y_coord      = 16'(y);
      row.rq.red          = 8'(r);
      row.rq.green        = 8'(g);
      row.rq.blue         = 8'(b);
      row.rq.alpha        = 8'(a);
      row.fixed           = fixed;
      row.want.pixel_value = 16'(pv);
      row.want.off_screen = off;
      return row;
   endfunction

   function automatic logic signed [15:0] border_coord(int span);
      case ($urandom_range(0, 5))
         0: return -16'sd1;
         1: return 16'sd0;
         2: return 16'(span - 1);
         3: return 16'(span);
         4: return 16'h8000;
         default: return 16'h7FFF;
      endcase
   endfunction

   // Present one transaction, hold it until accepted, then log its expected response.
   task automatic offer_request(req_payload_type rq, rsp_payload_type want, bit tx_calm);
      if (!quiet_tail && !tx_calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_data  <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixel_expect_q.push_back(want);
   endtask

   // Let every response drain and the core go idle.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_expect_q.size() != 0 || !req_ready) @(posedge clock);
   endtask

   task automatic set_address_mode(bit mode);
      drain_responses();
      csr_wr_data <= mode;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      page_mode = mode;
   endtask

   // Stimulus
   initial begin
      stim_row_type    directed_rows [];
      req_payload_type rq;
      rsp_payload_type want;
      int              pick;
      int              hot_x;
      int              hot_y;
      bit              tx_calm;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      page_mode   = MODE_LINEAR;
      quiet_tail  = 1'b0;
      foreach (pixel_mem[i]) pixel_mem[i] = '0;

      directed_rows = '{
         mk_row(REQ_READ,  0,      0,      0,   0,   0,   0,   1, 0,       0),
         mk_row(REQ_READ,  159,    127,    0,   0,   0,   0,   1, 0,       0),
         mk_row(REQ_WRITE, 0,      0,      255, 255, 255, 255, 1, 16'hFFFF, 0),
         mk_row(REQ_READ,  0,      0,      0,   0,   0,   0,   1, 16'hFFFF, 0),
         mk_row(REQ_WRITE, 159,    127,    128, 64,  8,   255, 1, 16'h8201, 0),
         mk_row(REQ_READ,  159,    127,    0,   0,   0,   0,   1, 16'h8201, 0),
         mk_row(REQ_WRITE, 0,      0,      0,   0,   0,   0,   0, 0,       0),
         mk_row(REQ_WRITE, 0,      0,      0,   0,   0,   128, 0, 0,       0),
         mk_row(REQ_WRITE, 0,      0,      255, 0,   255, 254, 0, 0,       0),
         mk_row(REQ_READ,  0,      0,      0,   0,   0,   0,   0, 0,       0),
         mk_row(REQ_WRITE, -1,     0,      255, 255, 255, 255, 1, 0,       1),
         mk_row(REQ_WRITE, 0,      -1,     255, 255, 255, 255, 1, 0,       1),
         mk_row(REQ_WRITE, 160,    5,      255, 255, 255, 100, 1, 0,       1),
         mk_row(REQ_WRITE, 5,      128,    255, 255, 255, 255, 1, 0,       1),
         mk_row(REQ_READ,  -32768, -32768, 0,   0,   0,   0,   1, 0,       1),
         mk_row(REQ_READ,  32767,  32767,  0,   0,   0,   0,   1, 0,       1),
         mk_row(REQ_READ,  1,      0,      0,   0,   0,   0,   0, 0,       0),
         mk_row(REQ_SPARE, 3,      3,      255, 255, 255, 255, 1, 0,       0),
         mk_row(REQ_CLEAR, 0,      0,      0,   0,   0,   0,   1, 0,       0),
         mk_row(REQ_READ,  0,      0,      0,   0,   0,   0,   1, 0,       0),
         mk_row(REQ_READ,  159,    127,    0,   0,   0,   0,   1, 0,       0),
         mk_row(REQ_WRITE, 7,      9,      10,  20,  30,  200, 0, 0,       0),
         mk_row(REQ_READ,  7,      9,      0,   0,   0,   0,   0, 0,       0)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_address_mode(MODE_LINEAR);
      foreach (directed_rows[i]) begin
         want = predict_pixel(directed_rows[i].rq);
         if (directed_rows[i].fixed) want = directed_rows[i].want;
         offer_request(directed_rows[i].rq, want, 1'b0);
      end

      hot_x   = 0;
      hot_y   = 0;
      tx_calm = 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         set_address_mode(phase % 2 == 0 ? MODE_PAGED : MODE_LINEAR);
         if (phase == PHASES - 1) quiet_tail = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               hot_x = $urandom_range(0, SCREEN_W - 4);
               hot_y = $urandom_range(0, SCREEN_H - 4);
            end
            if (n % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 999);
            if (pick < 500)      rq.req_type = REQ_WRITE;
            else if (pick < 965) rq.req_type = REQ_READ;
            else if (pick < 996) rq.req_type = REQ_SPARE;
            else                 rq.req_type = REQ_CLEAR;
            // Mostly on-screen drawing, clustered so reads see recent writes
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               rq.x_coord = 16'($urandom);
               rq.y_coord = 16'($urandom);
            end else if (pick == 1) begin
               rq.x_coord = border_coord(SCREEN_W);
               rq.y_coord = border_coord(SCREEN_H);
            end else if (pick < 6) begin
               rq.x_coord = 16'(hot_x + $urandom_range(0, 3));
               rq.y_coord = 16'(hot_y + $urandom_range(0, 3));
            end else begin
               rq.x_coord = 16'($urandom_range(0, SCREEN_W - 1));
               rq.y_coord = 16'($urandom_range(0, SCREEN_H - 1));
            end
            rq.red   = 8'($urandom);
            rq.green = 8'($urandom);
            rq.blue  = 8'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 4)       rq.alpha = ALPHA_OPAQUE;
            else if (pick == 4) rq.alpha = 8'd0;
            else if (pick == 5) rq.alpha = ALPHA_OPAQUE - 8'd1;
            else                rq.alpha = 8'($urandom);
            want = predict_pixel(rq);
            offer_request(rq, want, tx_calm);
         end
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pixel_expect_q.size() == 0)
         $display("rgb565_framebuffer_blend_store_core: match");
      else
         $display("rgb565_framebuffer_blend_store_core: mismatch");
      $finish;
   end

   // Response side: random backpressure, one long hold-off, scoring
   initial begin
      rsp_payload_type want;
      int              hold_left;
      int              cyc;
      bit              long_hold_done;
      bit              rx_calm;
      rsp_ready      = 1'b0;
      error_count    = 0;
      results_seen   = 0;
      hold_left      = 0;
      cyc            = 0;
      long_hold_done = 1'b0;
      rx_calm        = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cyc++;
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pixel_expect_q.size() == 0) begin
               if (error_count < 10)
                  $display("pixel check failed: unexpected transaction value=%h off=%b",
                           rsp_data.pixel_value, rsp_data.off_screen);
               error_count++;
            end else begin
               want = pixel_expect_q.pop_front();
               if (rsp_data.pixel_value !== want.pixel_value ||
                   rsp_data.off_screen !== want.off_screen) begin
                  if (error_count < 10)
                     $display({"pixel check failed at transaction %0d: ",
                               "value exp %h got %h, off exp %b got %b"},
                              results_seen, want.pixel_value, rsp_data.pixel_value,
                              want.off_screen, rsp_data.off_screen);
                  error_count++;
               end
            end
         end
         if (cyc % 256 == 0) rx_calm = ($urandom_range(0, 2) == 0);
         if (quiet_tail) begin
            hold_left = 0;
         end else if (hold_left > 0) begin
            hold_left--;
         end else if (!long_hold_done && results_seen >= 120) begin
            // Stall long enough for the core to back up into its request port
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 18);
         end
         rsp_ready <= (hold_left == 0);
      end
   end

   // Watchdog: abort when no transaction moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("rgb565_framebuffer_blend_store_core: mismatch");
            $finish;
         end
      end
   end

endmodule

>>> files.f
rtl/rgbfb_pkg.sv
rtl/rgbfb_ram.sv
rtl/rgbfb_ctrl.sv
rtl/rgbfb_dp.sv
rtl/rgb565_framebuffer_blend_store.sv
tb/sv/rgb565_framebuffer_blend_store_core_tb.sv
